// ----- hw/rtl/bfr_pkg.sv -----
// Shared types and constants for the button factory-reset controller.
// Used by bfr_front, bfr_queue, bfr_back and button_factory_reset_fsm.
// No dependencies.
`default_nettype none

package bfr_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int CMP_WIDTH   = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [TIME_WIDTH-1:0] stamp_t;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_PRESS = 2'd1,
    FUNC_DONE  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_FLIP      = 3'd1,
    ACT_BLINK     = 3'd2,
    ACT_REMOVE    = 3'd3,
    ACT_INIT_DONE = 3'd4,
    ACT_RESET     = 3'd5,
    ACT_REBOOT    = 3'd6
  } action_t;

  typedef enum logic [6:0] {
    ST_INIT            = 7'b0000001,
    ST_WAIT_INIT_DONE  = 7'b0000010,
    ST_WAIT_RESET      = 7'b0000100,
    ST_WAIT_RESET_DONE = 7'b0001000,
    ST_FSR_BEGIN       = 7'b0010000,
    ST_FSR_CONFIRM     = 7'b0100000,
    ST_FSR_DONE        = 7'b1000000
  } mode_t;

  localparam logic [2:0] CODE_INIT            = 3'd0;
  localparam logic [2:0] CODE_WAIT_INIT_DONE  = 3'd1;
  localparam logic [2:0] CODE_WAIT_RESET      = 3'd2;
  localparam logic [2:0] CODE_WAIT_RESET_DONE = 3'd3;
  localparam logic [2:0] CODE_FSR_BEGIN       = 3'd4;
  localparam logic [2:0] CODE_FSR_CONFIRM     = 3'd5;
  localparam logic [2:0] CODE_FSR_DONE        = 3'd6;

  typedef enum logic [2:0] {
    CFG_SHORT_PRESS_LIMIT   = 3'd0,
    CFG_HOLD_BEGIN_INTERVAL = 3'd1,
    CFG_CONFIRM_TIMEOUT     = 3'd2,
    CFG_INIT_FLIP_COUNT     = 3'd3,
    CFG_PRESS_FLIP_COUNT    = 3'd4
  } cfg_index_t;

  localparam logic [31:0] SHORT_PRESS_LIMIT_RESET   = 32'd1000;
  localparam logic [31:0] HOLD_BEGIN_INTERVAL_RESET = 32'd5000;
  localparam logic [31:0] CONFIRM_TIMEOUT_RESET     = 32'd5000;
  localparam logic [7:0]  INIT_FLIP_COUNT_RESET     = 8'd2;
  localparam logic [7:0]  PRESS_FLIP_COUNT_RESET    = 8'd4;

  typedef struct packed {
    func_t       func;
    logic        button_held;
    logic [31:0] now_time;
    logic [31:0] press_duration;
  } in_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] flips;
    logic       status;
    logic [2:0] state_now;
    logic       last;
  } out_t;

  typedef struct packed {
    action_t    act0;
    action_t    act1;
    logic       two;
    logic [7:0] flips;
    logic       status;
    logic [2:0] state_now;
  } cmd_t;

  function automatic logic [2:0] state_code(mode_t m);
    logic [2:0] c;
    case (m)
      ST_INIT:            c = CODE_INIT;
      ST_WAIT_INIT_DONE:  c = CODE_WAIT_INIT_DONE;
      ST_WAIT_RESET:      c = CODE_WAIT_RESET;
      ST_WAIT_RESET_DONE: c = CODE_WAIT_RESET_DONE;
      ST_FSR_BEGIN:       c = CODE_FSR_BEGIN;
      ST_FSR_CONFIRM:     c = CODE_FSR_CONFIRM;
      ST_FSR_DONE:        c = CODE_FSR_DONE;
      default:            c = CODE_INIT;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bfr_front.sv -----
// Front end: configuration registers, item accept, state machine update and
// classification of each item into one queued command.
// Depends on bfr_pkg.
`default_nettype none

module bfr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bfr_pkg::in_t  in_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          queue_full,
  output logic               push,
  output bfr_pkg::cmd_t      push_cmd
);
  import bfr_pkg::*;

  logic [31:0] short_press_limit;
  logic [31:0] hold_begin_interval;
  logic [31:0] confirm_timeout;
  logic [7:0]  init_flip_count;
  logic [7:0]  press_flip_count;

  mode_t  mode, mode_next;
  stamp_t stamp, stamp_next;
  logic   pending, pending_next;

  stamp_t now_t;
  stamp_t elapsed;
  logic   hold_hit;
  logic   confirm_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = queue_full;
  assign push      = in_valid && !queue_full;

  assign now_t       = stamp_t'(in_data.now_time);
  assign elapsed     = now_t - stamp;
  assign hold_hit    = CMP_WIDTH'(elapsed) >= CMP_WIDTH'(hold_begin_interval);
  assign confirm_hit = CMP_WIDTH'(elapsed) >= CMP_WIDTH'(confirm_timeout);

  always_comb begin
    mode_next          = mode;
    stamp_next         = stamp;
    pending_next       = pending;
    push_cmd.act0      = ACT_NONE;
    push_cmd.act1      = ACT_NONE;
    push_cmd.two       = 1'b0;
    push_cmd.flips     = '0;
    push_cmd.status    = 1'b0;
    case (in_data.func)
      FUNC_TICK: begin
        pending_next = 1'b0;
        case (mode)
          ST_INIT: begin
            if (!in_data.button_held) begin
              push_cmd.act0  = ACT_FLIP;
              push_cmd.flips = init_flip_count;
              mode_next      = ST_WAIT_INIT_DONE;
            end else begin
              stamp_next = now_t;
              mode_next  = ST_FSR_BEGIN;
            end
          end
          ST_WAIT_RESET: begin
            if (pending) begin
              push_cmd.act0  = ACT_FLIP;
              push_cmd.flips = press_flip_count;
              mode_next      = ST_WAIT_RESET_DONE;
            end
          end
          ST_FSR_BEGIN: begin
            if (!in_data.button_held) begin
              stamp_next    = '0;
              push_cmd.act0 = ACT_INIT_DONE;
              mode_next     = ST_WAIT_RESET;
            end else if (hold_hit) begin
              push_cmd.act0 = ACT_BLINK;
              stamp_next    = now_t;
              mode_next     = ST_FSR_CONFIRM;
            end
          end
          ST_FSR_CONFIRM: begin
            if (confirm_hit) begin
              push_cmd.act0 = ACT_REMOVE;
              push_cmd.act1 = ACT_INIT_DONE;
              push_cmd.two  = 1'b1;
              stamp_next    = '0;
              mode_next     = ST_WAIT_RESET;
            end else if (pending) begin
              push_cmd.act0 = ACT_RESET;
              push_cmd.act1 = ACT_REMOVE;
              push_cmd.two  = 1'b1;
              stamp_next    = '0;
              mode_next     = ST_FSR_DONE;
            end
          end
          ST_FSR_DONE: begin
            push_cmd.act0  = ACT_FLIP;
            push_cmd.flips = press_flip_count;
            mode_next      = ST_WAIT_RESET_DONE;
          end
          default: begin
          end
        endcase
      end
      FUNC_PRESS: begin
        if (in_data.press_duration > short_press_limit) begin
          push_cmd.status = 1'b1;
        end else begin
          pending_next = 1'b1;
        end
      end
      FUNC_DONE: begin
        if (mode == ST_WAIT_INIT_DONE) begin
          push_cmd.act0 = ACT_REMOVE;
          push_cmd.act1 = ACT_INIT_DONE;
          push_cmd.two  = 1'b1;
          mode_next     = ST_WAIT_RESET;
        end else if (mode == ST_WAIT_RESET_DONE) begin
          push_cmd.act0 = ACT_REMOVE;
          push_cmd.act1 = ACT_REBOOT;
          push_cmd.two  = 1'b1;
        end else begin
          push_cmd.status = 1'b1;
        end
      end
      default: begin
      end
    endcase
    push_cmd.state_now = state_code(mode_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= ST_INIT;
      stamp   <= '0;
      pending <= 1'b0;
    end else if (push) begin
      mode    <= mode_next;
      stamp   <= stamp_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_press_limit   <= SHORT_PRESS_LIMIT_RESET;
      hold_begin_interval <= HOLD_BEGIN_INTERVAL_RESET;
      confirm_timeout     <= CONFIRM_TIMEOUT_RESET;
      init_flip_count     <= INIT_FLIP_COUNT_RESET;
      press_flip_count    <= PRESS_FLIP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHORT_PRESS_LIMIT:   short_press_limit   <= cfg_data;
        CFG_HOLD_BEGIN_INTERVAL: hold_begin_interval <= cfg_data;
        CFG_CONFIRM_TIMEOUT:     confirm_timeout     <= cfg_data;
        CFG_INIT_FLIP_COUNT:     init_flip_count     <= cfg_data[7:0];
        CFG_PRESS_FLIP_COUNT:    press_flip_count    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bfr_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on bfr_pkg.
`default_nettype none

module bfr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bfr_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output bfr_pkg::cmd_t      head_cmd
);
  import bfr_pkg::*;

  cmd_t                  entry [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full       = count == QCNT_WIDTH'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [QPTR_WIDTH-1:0] ptr_inc(logic [QPTR_WIDTH-1:0] p);
    logic [QPTR_WIDTH-1:0] r;
    if (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_WIDTH'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> full)
    else $error("queue left full state without a pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- hw/rtl/bfr_back.sv -----
// Back end: expands each queued command into one or two result words and
// holds them in the output register.
// Depends on bfr_pkg.
`default_nettype none

module bfr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire bfr_pkg::cmd_t head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bfr_pkg::out_t      out_data
);
  import bfr_pkg::*;

  logic sel;
  logic load;
  out_t word;

  assign load = !out_valid || !out_stall;
  assign pop  = load && head_valid && word.last;

  always_comb begin
    word.action    = sel ? head_cmd.act1 : head_cmd.act0;
    word.flips     = sel ? 8'd0 : head_cmd.flips;
    word.status    = sel ? 1'b0 : head_cmd.status;
    word.state_now = head_cmd.state_now;
    word.last      = sel || !head_cmd.two;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      sel       <= head_valid && !word.last;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_data <= word;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/button_factory_reset_fsm.sv -----
// Top level of the button start-up and factory-reset controller.
// Instantiates bfr_front, bfr_queue and bfr_back; depends on bfr_pkg.
// Input items are accepted one per cycle while the two-entry command queue
// has room; the state machine advances at accept. Each item yields one or two
// result words, and the back end's single output register sends one word a
// cycle while out_stall is low. Configuration writes are always ready and take
// effect on the next cycle.
`default_nettype none

module button_factory_reset_fsm (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bfr_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bfr_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);
  import bfr_pkg::*;

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  bfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  bfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  bfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_first_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !out_data.status)
    else $error("first of two results carries an error status");

  a_flip_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action == ACT_FLIP |-> out_data.last)
    else $error("flip result not final");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last && !out_stall |=> out_valid)
    else $error("second result did not follow the first");

  a_second_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |->
      out_data.action == ACT_REMOVE || out_data.action == ACT_RESET)
    else $error("unexpected first action of a pair");

endmodule

`default_nettype wire
